// ===== rtl/vab_pkg.sv =====
package vab_pkg;

  // Design constants.
  localparam int CORDIC_STEPS = 16;
  localparam int COORD_BITS   = 12;

  // Angles are binary fractions of a full turn.
  localparam int ANGLE_W = 32;
  localparam int ATAN_LEN = 24;

  // Coordinates are scaled by 2^16 and need headroom for the CORDIC gain.
  localparam int PRESHIFT = 16;
  localparam int DATA_W   = COORD_BITS + PRESHIFT + 3;

  // Output in 1/64 degree.
  localparam int OUT_W   = 15;
  localparam int PROD_W  = ANGLE_W + OUT_W;
  localparam logic [OUT_W-1:0] DEG64_PER_TURN = OUT_W'(23040);

  localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  // Pipeline: one prep stage, one stage per iteration, difference, scaling.
  localparam int NUM_STAGES = CORDIC_STEPS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DATA_W-1:0]     data_t;
  typedef logic [ANGLE_W-1:0]           angle_t;
  typedef logic [OUT_W-1:0]             deg64_t;

  // atan(2^-i) in units of a full turn over 2^32, rounded.
  localparam angle_t ATAN_TURN [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

// ===== rtl/vab_in_if.sv =====
interface vab_in_if;
  import vab_pkg::*;

  logic   valid;
  logic   ready;
  coord_t a_x;
  coord_t a_y;
  coord_t b_x;
  coord_t b_y;

  modport source (output valid, output a_x, output a_y, output b_x, output b_y,
                  input ready);
  modport sink (input valid, input a_x, input a_y, input b_x, input b_y,
                output ready);
endinterface

// ===== rtl/vab_out_if.sv =====
interface vab_out_if;
  import vab_pkg::*;

  logic   valid;
  logic   ready;
  deg64_t angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink (input valid, input angle_deg, output ready);
endinterface

// ===== rtl/vector_angle_between.sv =====
// Angle of vector a relative to vector b, in 1/64 degree within [0, 360).
// Both vectors run through their own pipelined 16-iteration CORDIC, one
// iteration per register stage, so a new item is taken every cycle unless a
// stalled output has filled every stage; the stages are prep, 16 iterations,
// difference and scaling multiply. Stages stall on their own: a bubble in the
// pipeline is filled even while the output waits, so input ready only drops
// when every stage holds an item. A zero vector counts as angle 0.
module vector_angle_between (
  input  logic      clk_i,
  input  logic      rst_ni,
  vab_in_if.sink    in_i,
  vab_out_if.source out_o
);
  import vab_pkg::*;

  localparam int DIFF_STG = CORDIC_STEPS + 1;
  localparam int OUT_STG  = CORDIC_STEPS + 2;

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   rdy;

  // A stage may load when it is empty or its successor takes its item.
  always_comb begin
    rdy[NUM_STAGES] = out_o.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_i.ready = rdy[0];

  // The two CORDIC lanes share the stage enables.
  angle_t ang_a, ang_b;

  vab_cordic u_cordic_a (
    .clk_i   (clk_i),
    .en_i    (rdy[CORDIC_STEPS:0]),
    .x_i     (in_i.a_x),
    .y_i     (in_i.a_y),
    .angle_o (ang_a)
  );

  vab_cordic u_cordic_b (
    .clk_i   (clk_i),
    .en_i    (rdy[CORDIC_STEPS:0]),
    .x_i     (in_i.b_x),
    .y_i     (in_i.b_y),
    .angle_o (ang_b)
  );

  // Difference of the turn fractions wraps into [0, 360) by itself.
  angle_t diff_q;

  always_ff @(posedge clk_i) begin
    if (rdy[DIFF_STG]) diff_q <= ang_a - ang_b;
  end

  // Scale to 1/64 degree: keep the top bits of diff * 23040.
  logic [PROD_W-1:0] prod;
  deg64_t            angle_q;

  assign prod = PROD_W'(diff_q) * PROD_W'(DEG64_PER_TURN);

  always_ff @(posedge clk_i) begin
    if (rdy[OUT_STG]) angle_q <= prod[ANGLE_W +: OUT_W];
  end

  assign out_o.valid     = vld_q[OUT_STG];
  assign out_o.angle_deg = angle_q;

  // Input back-pressure only when every stage is occupied.
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> &vld_q)
    else $error("input stalled while the pipeline has a free stage");

  // An accepted item occupies the prep stage in the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted item lost at the prep stage");

  // Results always lie below a full turn.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.angle_deg < DEG64_PER_TURN))
    else $error("angle out of range");

endmodule

// ===== rtl/vab_cordic.sv =====
// Pipelined vectoring CORDIC: one prep stage, then one iteration per stage.
module vab_cordic (
  input  logic                       clk_i,
  input  logic [vab_pkg::CORDIC_STEPS:0] en_i,
  input  vab_pkg::coord_t            x_i,
  input  vab_pkg::coord_t            y_i,
  output vab_pkg::angle_t            angle_o
);
  import vab_pkg::*;

  data_t  x_q [CORDIC_STEPS+1];
  data_t  y_q [CORDIC_STEPS+1];
  angle_t z_q [CORDIC_STEPS+1];
  logic   byp_q [CORDIC_STEPS+1];

  // Prep: axis and zero vectors get an exact angle, left half-plane is turned.
  logic signed [COORD_BITS:0] x_ext, y_ext, x_rot, y_rot;
  logic   x_neg, on_axis;
  angle_t z_init;

  always_comb begin
    x_ext   = (COORD_BITS+1)'(x_i);
    y_ext   = (COORD_BITS+1)'(y_i);
    x_neg   = x_i[COORD_BITS-1];
    on_axis = (y_i == '0) || (x_i == '0);
    x_rot   = x_neg ? -x_ext : x_ext;
    y_rot   = x_neg ? -y_ext : y_ext;
    if (y_i == '0) begin
      z_init = x_neg ? HALF_TURN : '0;
    end else if (x_i == '0) begin
      z_init = y_i[COORD_BITS-1] ? THREE_QUARTER_TURN : QUARTER_TURN;
    end else begin
      z_init = x_neg ? HALF_TURN : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0]   <= DATA_W'(x_rot) <<< PRESHIFT;
      y_q[0]   <= DATA_W'(y_rot) <<< PRESHIFT;
      z_q[0]   <= z_init;
      byp_q[0] <= on_axis;
    end
  end

  // One rotation per stage; the sign of y picks the direction.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    data_t  x_d, y_d;
    angle_t z_d;

    always_comb begin
      x_d = x_q[i];
      y_d = y_q[i];
      z_d = z_q[i];
      if (i < ATAN_LEN && !byp_q[i]) begin
        if (!y_q[i][DATA_W-1]) begin
          x_d = x_q[i] + (y_q[i] >>> i);
          y_d = y_q[i] - (x_q[i] >>> i);
          z_d = z_q[i] + ATAN_TURN[i % ATAN_LEN];
        end else begin
          x_d = x_q[i] - (y_q[i] >>> i);
          y_d = y_q[i] + (x_q[i] >>> i);
          z_d = z_q[i] - ATAN_TURN[i % ATAN_LEN];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        x_q[i+1]   <= x_d;
        y_q[i+1]   <= y_d;
        z_q[i+1]   <= z_d;
        byp_q[i+1] <= byp_q[i];
      end
    end
  end

  assign angle_o = z_q[CORDIC_STEPS];

endmodule
